@@ design/dahdsr_volume_envelope_core_defines.svh @@
// Assertion macros for the DAHDSR volume envelope core.
`ifndef DAHDSR_VOLUME_ENVELOPE_CORE_DEFINES_SVH
`define DAHDSR_VOLUME_ENVELOPE_CORE_DEFINES_SVH
`ifndef SYNTH
`define DVE_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("envelope core check failed");
`define DVE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("envelope core check failed");
`else
`define DVE_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define DVE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

@@ design/dve_pkg.sv @@
// Shared widths, codes and gain table builder for the DAHDSR volume envelope.
`timescale 1ns / 1ps
`default_nettype none
package dve_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 24;
  localparam int SILENCE_CB   = 1000;

  localparam int REG_BITS     = 24;
  localparam int CB_REG_BITS  = 10;
  localparam int DATA_BITS    = 32;
  localparam int REG_IDX_BITS = 3;
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;

  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 15;
  localparam int CB_BITS      = $clog2(SILENCE_CB + 1);
  localparam int CBX_BITS     = CB_BITS + 1;
  localparam int ROM_AW       = $clog2(SILENCE_CB);
  localparam int PROD_BITS    = GAIN_BITS + REG_BITS;
  localparam int MA_BITS      = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;
  localparam int MB_BITS      = (REG_BITS > GAIN_BITS) ? REG_BITS : GAIN_BITS;
  localparam int P_BITS       = MA_BITS + MB_BITS;
  localparam int LEN_BITS     = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
  localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);

  localparam logic [63:0] CB_STEP_Q32 = 64'd4245803212;

  localparam logic [CB_BITS-1:0]  SILENCE_C = CB_BITS'(SILENCE_CB);
  localparam logic [CBX_BITS-1:0] SILENCE_X = CBX_BITS'(SILENCE_CB);

  localparam int LEVEL_MAX_INT = (1 << CB_REG_BITS) - 1;
  localparam int LEVEL_SAT_INT = (SILENCE_CB > LEVEL_MAX_INT) ? LEVEL_MAX_INT : SILENCE_CB;
  localparam logic [CB_REG_BITS-1:0] LEVEL_MAX    = CB_REG_BITS'(LEVEL_MAX_INT);
  localparam logic [CB_REG_BITS-1:0] LEVEL_SILENT = CB_REG_BITS'(LEVEL_SAT_INT);

  localparam logic [REG_IDX_BITS-1:0] REG_DELAY   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HOLD    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_PEAK    = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_OFFSET  = 3'd7;

  typedef enum logic [2:0] {
    PH_DELAY   = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5
  } phase_t;

  typedef logic [GAIN_BITS-1:0] gain_rom_t [SILENCE_CB];

  // Q1.15 gain per centibel, built by repeated multiplication in Q0.32.
  function automatic gain_rom_t build_gain_rom();
    gain_rom_t   rom;
    logic [63:0] g;
    g = 64'd1 << 32;
    for (int c = 0; c < SILENCE_CB; c++) begin
      rom[c] = GAIN_BITS'((g + 64'd65536) >> 17);
      g = (g * CB_STEP_Q32) >> 32;
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

@@ design/dve_in_if.sv @@
// Input sample channel: valid/ready handshake with sample and note flags.
`timescale 1ns / 1ps
`default_nettype none
interface dve_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dve_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                  note_on;
  logic                                  note_off;

  modport source (output valid, output sample_in, output note_on, output note_off,
                  input ready);
  modport sink   (input valid, input sample_in, input note_on, input note_off,
                  output ready);
endinterface
`default_nettype wire

@@ design/dve_out_if.sv @@
// Result channel: valid/ready handshake with scaled sample and envelope status.
`timescale 1ns / 1ps
`default_nettype none
interface dve_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dve_pkg::SAMPLE_BITS-1:0] sample_out;
  logic [dve_pkg::CB_REG_BITS-1:0]        level_cb;
  logic [2:0]                             phase;
  logic                                   finished;

  modport source (output valid, output sample_out, output level_cb, output phase,
                  output finished, input ready);
  modport sink   (input valid, input sample_out, input level_cb, input phase,
                  input finished, output ready);
endinterface
`default_nettype wire

@@ design/dahdsr_volume_envelope_core.sv @@
// Top level of the DAHDSR volume envelope: sequencer, shared multiplier, divider and gain ROM.
`timescale 1ns / 1ps
`default_nettype none
`include "dahdsr_volume_envelope_core_defines.svh"
// One voice envelope. Each input transfer carries one sample; the core then runs a
// sequencer over a single multiplier, a radix-2 divider of 16 steps and a one-port gain
// ROM with registered read, and takes no new sample until the result is in the output
// register. A delay, hold or sustain sample, or a release sample past its length, passes
// through resolve, final, gain lookup and output; a decay or release sample adds one
// multiply and 16 divide steps; an attack sample adds two multiply/divide passes and a
// binary search of the gain ROM of at most 10 probes. Each phase passed over on the way
// adds another resolve step. A result waiting in the output register does not block the
// next sample; only when a second result is ready before the first was taken does the
// core wait. Registers are to be written over the APB-style port while the core is idle;
// the core does not enforce this, and there is no clearing pass.
module dahdsr_volume_envelope_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  dve_in_if.sink                               in_if,
  dve_out_if.source                            out_if,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [dve_pkg::ADDR_BITS-1:0]        paddr,
  input  wire  [dve_pkg::DATA_BITS-1:0]        pwdata,
  output logic [dve_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  localparam int SB  = dve_pkg::SAMPLE_BITS;
  localparam int CNB = dve_pkg::COUNT_BITS;
  localparam int RB  = dve_pkg::REG_BITS;
  localparam int CRB = dve_pkg::CB_REG_BITS;
  localparam int GB  = dve_pkg::GAIN_BITS;
  localparam int CB  = dve_pkg::CB_BITS;
  localparam int CBX = dve_pkg::CBX_BITS;
  localparam int AW  = dve_pkg::ROM_AW;
  localparam int MA  = dve_pkg::MA_BITS;
  localparam int MB  = dve_pkg::MB_BITS;
  localparam int PB  = dve_pkg::P_BITS;
  localparam int LB  = dve_pkg::LEN_BITS;
  localparam int DCB = dve_pkg::DIV_CNT_BITS;

  localparam dve_pkg::gain_rom_t GainRom = dve_pkg::build_gain_rom();

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESOLVE,
    S_ATK_MUL,
    S_DIV_INIT,
    S_DIV,
    S_SRCH_A,
    S_SRCH_B,
    S_FINAL,
    S_GLOOK,
    S_OUT
  } state_t;

  // configuration registers
  logic [RB-1:0]  delay_samples_r, attack_samples_r, hold_samples_r;
  logic [RB-1:0]  decay_samples_r, release_samples_r;
  logic [CRB-1:0] peak_cb_r, sustain_cb_r, offset_cb_r;

  // sequencer and envelope state
  state_t                      state_r, state_nxt;
  dve_pkg::phase_t             phase_r, phase_nxt;
  logic [CNB-1:0]              count_r, count_nxt;
  logic [CB-1:0]               rel_start_r, rel_start_nxt;
  logic [CB-1:0]               cur_cb_r, cur_cb_nxt;
  logic                        done_r, done_nxt;
  logic [SB-1:0]               mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;
  logic [CB-1:0]               level_r, level_nxt;
  logic [GB-1:0]               gain_r, gain_nxt;
  logic                        gain_set_r, gain_set_nxt;
  logic                        atk_second_r, atk_second_nxt;
  logic [CB-1:0]               lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [RB-1:0]               div_d_r, div_d_nxt;
  logic [RB-1:0]               div_rem_r, div_rem_nxt;
  logic [GB-1:0]               div_quo_r, div_quo_nxt;
  logic [DCB-1:0]              div_cnt_r, div_cnt_nxt;
  logic [PB-1:0]               prod_r, prod_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]        out_sample_r, out_sample_nxt;
  logic [CRB-1:0]              out_level_r, out_level_nxt;
  logic [2:0]                  out_phase_r, out_phase_nxt;
  logic                        out_finished_r, out_finished_nxt;

  // shared units
  logic [MA-1:0]  mul_a;
  logic [MB-1:0]  mul_b;
  logic [PB-1:0]  mul_p;
  logic [CBX-1:0] rom_x;
  logic [AW-1:0]  rom_addr;
  logic [GB-1:0]  rom_q_r;
  logic           rom_zero_r;
  logic [GB-1:0]  gain_rd;

  // derived values
  logic [CB-1:0]  peak, sust;
  logic [CBX-1:0] peak_x, sust_x;
  logic [RB-1:0]  atk_len, dec_len, rel_len;
  logic [RB-1:0]  n_div;
  logic [RB:0]    div_t;
  logic           div_ge;
  logic [GB-1:0]  div_q;
  logic [CBX-1:0] mid_sum;
  logic [SB-1:0]  pm;
  logic           in_xfer, out_xfer, cfg_wr, fin;

  function automatic logic len_reached(input logic [CNB-1:0] n, input logic [RB-1:0] len);
    return LB'(n) >= LB'(len);
  endfunction

  function automatic logic [RB-1:0] nonzero_len(input logic [RB-1:0] len);
    return (len == '0) ? RB'(1) : len;
  endfunction

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_valid_r && out_if.ready;

  assign in_if.ready       = (state_r == S_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.level_cb   = out_level_r;
  assign out_if.phase      = out_phase_r;
  assign out_if.finished   = out_finished_r;

  // configuration write and read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_samples_r   <= '0;
      attack_samples_r  <= RB'(1);
      hold_samples_r    <= '0;
      decay_samples_r   <= RB'(1);
      release_samples_r <= RB'(1);
      peak_cb_r         <= '0;
      sustain_cb_r      <= '0;
      offset_cb_r       <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[dve_pkg::ADDR_BITS-1:2])
        dve_pkg::REG_DELAY:   delay_samples_r   <= pwdata[RB-1:0];
        dve_pkg::REG_ATTACK:  attack_samples_r  <= pwdata[RB-1:0];
        dve_pkg::REG_HOLD:    hold_samples_r    <= pwdata[RB-1:0];
        dve_pkg::REG_DECAY:   decay_samples_r   <= pwdata[RB-1:0];
        dve_pkg::REG_RELEASE: release_samples_r <= pwdata[RB-1:0];
        dve_pkg::REG_PEAK:    peak_cb_r         <= pwdata[CRB-1:0];
        dve_pkg::REG_SUSTAIN: sustain_cb_r      <= pwdata[CRB-1:0];
        dve_pkg::REG_OFFSET:  offset_cb_r       <= pwdata[CRB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[dve_pkg::ADDR_BITS-1:2])
      dve_pkg::REG_DELAY:   prdata = dve_pkg::DATA_BITS'(delay_samples_r);
      dve_pkg::REG_ATTACK:  prdata = dve_pkg::DATA_BITS'(attack_samples_r);
      dve_pkg::REG_HOLD:    prdata = dve_pkg::DATA_BITS'(hold_samples_r);
      dve_pkg::REG_DECAY:   prdata = dve_pkg::DATA_BITS'(decay_samples_r);
      dve_pkg::REG_RELEASE: prdata = dve_pkg::DATA_BITS'(release_samples_r);
      dve_pkg::REG_PEAK:    prdata = dve_pkg::DATA_BITS'(peak_cb_r);
      dve_pkg::REG_SUSTAIN: prdata = dve_pkg::DATA_BITS'(sustain_cb_r);
      dve_pkg::REG_OFFSET:  prdata = dve_pkg::DATA_BITS'(offset_cb_r);
      default:              prdata = '0;
    endcase
  end

  // derived levels and lengths
  always_comb begin
    peak_x  = CBX'(peak_cb_r);
    peak    = (peak_x > dve_pkg::SILENCE_X) ? dve_pkg::SILENCE_C : CB'(peak_x);
    sust_x  = CBX'(peak) + CBX'(sustain_cb_r);
    sust    = (sust_x > dve_pkg::SILENCE_X) ? dve_pkg::SILENCE_C : CB'(sust_x);
    atk_len = nonzero_len(attack_samples_r);
    dec_len = nonzero_len(decay_samples_r);
    rel_len = nonzero_len(release_samples_r);
    n_div   = RB'(count_r);
    mid_sum = (CBX'(lo_r) + CBX'(hi_r)) >> 1;
    div_t   = {div_rem_r, div_quo_r[GB-1]};
    div_ge  = (div_t >= {1'b0, div_d_r});
    div_q   = {div_quo_r[GB-2:0], div_ge};
    pm      = prod_r[dve_pkg::GAIN_FRAC +: SB];
    fin     = done_r || ((phase_r == dve_pkg::PH_RELEASE) &&
              ((CBX'(level_r) + CBX'(offset_cb_r)) >= dve_pkg::SILENCE_X));
  end

  // shared multiplier and gain ROM
  assign mul_p    = PB'(mul_a) * PB'(mul_b);
  assign rom_addr = (rom_x >= dve_pkg::SILENCE_X) ? '0 : rom_x[AW-1:0];
  assign gain_rd  = rom_zero_r ? '0 : rom_q_r;

  always_ff @(posedge clk) begin
    rom_q_r    <= GainRom[rom_addr];
    rom_zero_r <= (rom_x >= dve_pkg::SILENCE_X);
  end

  // sequencer next state
  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    count_nxt        = count_r;
    rel_start_nxt    = rel_start_r;
    cur_cb_nxt       = cur_cb_r;
    done_nxt         = done_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    level_nxt        = level_r;
    gain_nxt         = gain_r;
    gain_set_nxt     = gain_set_r;
    atk_second_nxt   = atk_second_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    div_d_nxt        = div_d_r;
    div_rem_nxt      = div_rem_r;
    div_quo_nxt      = div_quo_r;
    div_cnt_nxt      = div_cnt_r;
    prod_nxt         = prod_r;
    out_valid_nxt    = out_xfer ? 1'b0 : out_valid_r;
    out_sample_nxt   = out_sample_r;
    out_level_nxt    = out_level_r;
    out_phase_nxt    = out_phase_r;
    out_finished_nxt = out_finished_r;
    mul_a            = '0;
    mul_b            = '0;
    rom_x            = CBX'(peak);

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          neg_nxt      = in_if.sample_in[SB-1];
          mag_nxt      = in_if.sample_in[SB-1] ? (~in_if.sample_in + SB'(1))
                                               : in_if.sample_in;
          gain_set_nxt = 1'b0;
          if (in_if.note_on) begin
            phase_nxt = dve_pkg::PH_DELAY;
            count_nxt = '0;
            done_nxt  = 1'b0;
          end else if (in_if.note_off && (phase_r != dve_pkg::PH_RELEASE)) begin
            rel_start_nxt = cur_cb_r;
            phase_nxt     = dve_pkg::PH_RELEASE;
            count_nxt     = '0;
          end
          state_nxt = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        unique case (phase_r)
          dve_pkg::PH_DELAY: begin
            if (len_reached(count_r, delay_samples_r)) begin
              phase_nxt = dve_pkg::PH_ATTACK;
              count_nxt = '0;
            end else begin
              level_nxt    = dve_pkg::SILENCE_C;
              gain_nxt     = '0;
              gain_set_nxt = 1'b1;
              state_nxt    = S_FINAL;
            end
          end
          dve_pkg::PH_ATTACK: begin
            if (len_reached(count_r, atk_len)) begin
              phase_nxt = dve_pkg::PH_HOLD;
              count_nxt = '0;
            end else begin
              rom_x          = CBX'(peak);
              div_d_nxt      = atk_len;
              atk_second_nxt = 1'b0;
              state_nxt      = S_ATK_MUL;
            end
          end
          dve_pkg::PH_HOLD: begin
            if (len_reached(count_r, hold_samples_r)) begin
              phase_nxt = dve_pkg::PH_DECAY;
              count_nxt = '0;
            end else begin
              level_nxt = peak;
              state_nxt = S_FINAL;
            end
          end
          dve_pkg::PH_DECAY: begin
            if (len_reached(count_r, dec_len)) begin
              phase_nxt = dve_pkg::PH_SUSTAIN;
              count_nxt = '0;
            end else begin
              mul_a     = MA'(sust - peak);
              mul_b     = MB'(n_div);
              prod_nxt  = mul_p;
              div_d_nxt = dec_len;
              state_nxt = S_DIV_INIT;
            end
          end
          dve_pkg::PH_SUSTAIN: begin
            level_nxt = sust;
            state_nxt = S_FINAL;
          end
          dve_pkg::PH_RELEASE: begin
            if (len_reached(count_r, rel_len)) begin
              level_nxt = dve_pkg::SILENCE_C;
              state_nxt = S_FINAL;
            end else begin
              mul_a     = MA'(dve_pkg::SILENCE_C - rel_start_r);
              mul_b     = MB'(n_div);
              prod_nxt  = mul_p;
              div_d_nxt = rel_len;
              state_nxt = S_DIV_INIT;
            end
          end
          default: phase_nxt = dve_pkg::PH_RELEASE;
        endcase
      end

      S_ATK_MUL: begin
        mul_a     = MA'(gain_rd);
        mul_b     = MB'(n_div);
        prod_nxt  = mul_p;
        state_nxt = S_DIV_INIT;
      end

      S_DIV_INIT: begin
        div_rem_nxt = prod_r[dve_pkg::PROD_BITS-1:GB];
        div_quo_nxt = prod_r[GB-1:0];
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end

      S_DIV: begin
        div_rem_nxt = div_ge ? RB'(div_t - {1'b0, div_d_r}) : div_t[RB-1:0];
        div_quo_nxt = div_q;
        div_cnt_nxt = div_cnt_r + DCB'(1);
        if (div_cnt_r == DCB'(GB - 1)) begin
          if (phase_r == dve_pkg::PH_ATTACK) begin
            if (atk_second_r) begin
              gain_nxt     = div_q;
              gain_set_nxt = 1'b1;
              state_nxt    = S_FINAL;
            end else if (div_q == '0) begin
              level_nxt      = dve_pkg::SILENCE_C;
              rom_x          = CBX'(peak) + CBX'(offset_cb_r);
              atk_second_nxt = 1'b1;
              state_nxt      = S_ATK_MUL;
            end else begin
              gain_nxt  = div_q;
              lo_nxt    = '0;
              hi_nxt    = dve_pkg::SILENCE_C;
              state_nxt = S_SRCH_A;
            end
          end else if (phase_r == dve_pkg::PH_DECAY) begin
            level_nxt = peak + CB'(div_q);
            state_nxt = S_FINAL;
          end else begin
            level_nxt = rel_start_r + CB'(div_q);
            state_nxt = S_FINAL;
          end
        end
      end

      S_SRCH_A: begin
        if (lo_r < hi_r) begin
          mid_nxt   = AW'(mid_sum);
          rom_x     = mid_sum;
          state_nxt = S_SRCH_B;
        end else begin
          level_nxt      = lo_r;
          rom_x          = CBX'(peak) + CBX'(offset_cb_r);
          atk_second_nxt = 1'b1;
          state_nxt      = S_ATK_MUL;
        end
      end

      S_SRCH_B: begin
        if (gain_rd <= gain_r) begin
          hi_nxt = CB'(mid_r);
        end else begin
          lo_nxt = CB'(mid_r) + CB'(1);
        end
        state_nxt = S_SRCH_A;
      end

      S_FINAL: begin
        rom_x    = CBX'(level_r) + CBX'(offset_cb_r);
        done_nxt = fin;
        if (fin) begin
          level_nxt    = dve_pkg::SILENCE_C;
          gain_nxt     = '0;
          gain_set_nxt = 1'b1;
        end
        state_nxt = S_GLOOK;
      end

      S_GLOOK: begin
        mul_a     = MA'(mag_r);
        mul_b     = MB'(gain_set_r ? gain_r : gain_rd);
        prod_nxt  = mul_p;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt    = 1'b1;
          out_sample_nxt   = neg_r ? (~pm + SB'(1)) : pm;
          out_level_nxt    = (CBX'(level_r) > CBX'(dve_pkg::LEVEL_MAX)) ? dve_pkg::LEVEL_MAX
                                                                        : CRB'(level_r);
          out_phase_nxt    = phase_r;
          out_finished_nxt = done_r;
          cur_cb_nxt       = level_r;
          if (~&count_r) count_nxt = count_r + CNB'(1);
          state_nxt        = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= dve_pkg::PH_DELAY;
      count_r     <= '0;
      rel_start_r <= dve_pkg::SILENCE_C;
      cur_cb_r    <= dve_pkg::SILENCE_C;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      rel_start_r <= rel_start_nxt;
      cur_cb_r    <= cur_cb_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r          <= mag_nxt;
    neg_r          <= neg_nxt;
    level_r        <= level_nxt;
    gain_r         <= gain_nxt;
    gain_set_r     <= gain_set_nxt;
    atk_second_r   <= atk_second_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    mid_r          <= mid_nxt;
    div_d_r        <= div_d_nxt;
    div_rem_r      <= div_rem_nxt;
    div_quo_r      <= div_quo_nxt;
    div_cnt_r      <= div_cnt_nxt;
    prod_r         <= prod_nxt;
    out_sample_r   <= out_sample_nxt;
    out_level_r    <= out_level_nxt;
    out_phase_r    <= out_phase_nxt;
    out_finished_r <= out_finished_nxt;
  end

  `DVE_ASSERT_IMPLY(a_finished_silent, clk, rst_n, out_valid_r && out_finished_r,
                    (out_sample_r == '0) && (out_level_r == dve_pkg::LEVEL_SILENT) &&
                    (out_phase_r == dve_pkg::PH_RELEASE))
  `DVE_ASSERT_IMPLY(a_div_rem_below, clk, rst_n, state_r == S_DIV, div_rem_r < div_d_r)
  `DVE_ASSERT_IMPLY(a_search_bounds, clk, rst_n, state_r == S_SRCH_A,
                    (lo_r <= hi_r) && (hi_r <= dve_pkg::SILENCE_C))
  `DVE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_xfer,
                   (state_r == S_RESOLVE) && !in_if.ready)

endmodule
`default_nettype wire
